>>> sv/mau_pkg.sv
package mau_pkg;

  localparam int unsigned DefValueWidth = 31;
  localparam logic [61:0] ResetModulus = 62'd998244353;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INV = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_MUL,
    ST_EUC_DIV,
    ST_EUC_QMUL,
    ST_EUC_UPD,
    ST_EUC_DONE,
    ST_DONE
  } state_t;

endpackage

>>> sv/modular_arithmetic_unit_core.sv
// add, subtract and negate reduce both operands by restoring division before the result is
// valid; multiply then adds shift-and-add steps
// divide and inverse run extended euclid, each round a division, a modular multiply and one
// update, then a final step; divide adds a last multiply
// one item at a time: in_ready returns in the cycle after the result item is taken
// reset: synchronous active-high rst clears control and loads modulus with 998244353
module modular_arithmetic_unit_core #(
  parameter int unsigned VALUE_WIDTH = mau_pkg::DefValueWidth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             opcode,
  input  logic [VALUE_WIDTH-1:0] operand_a,
  input  logic [VALUE_WIDTH-1:0] operand_b,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] result,
  output logic                   no_inverse
);
  import mau_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  state_t state, state_next;

  logic [W-1:0] modulus;
  logic [2:0]   op;
  logic [W-1:0] a, b;
  logic [W-1:0] r0, r1, t0, t1;
  logic [W-1:0] quo;
  logic [W:0]   acc;
  logic [W-1:0] mx, my;
  logic [CW-1:0] cnt;
  logic [W-1:0] res_q;
  logic         flag_q;
  logic         euc_for_div;

  // shared unit: one restoring-division step or one shift-and-add step
  logic [W+1:0] dshift;
  logic [W+1:0] ddiff;
  logic [W+1:0] mdbl, madd;
  logic [W:0]   mdbl_r, madd_r;
  logic [W-1:0] dsor;
  logic [W-1:0] dnum;

  always_comb begin
    dshift = {acc, dnum[W-1]};
    ddiff  = dshift - {2'b00, dsor};
    mdbl   = {acc, 1'b0};
    mdbl_r = (mdbl >= {2'b00, modulus}) ? (W+1)'(mdbl - {2'b00, modulus}) : mdbl[W:0];
    madd   = {1'b0, mdbl_r} + (my[W-1] ? {2'b00, mx} : '0);
    madd_r = (madd >= {2'b00, modulus}) ? (W+1)'(madd - {2'b00, modulus}) : madd[W:0];
  end

  // dividend in quo register shifts left; divisor choice per state
  assign dnum = quo;
  always_comb begin
    case (state)
      ST_EUC_DIV: dsor = r1;
      default:    dsor = modulus;
    endcase
  end

  assign pready   = 1'b1;
  assign prdata   = 32'(modulus);
  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign result   = res_q;
  assign no_inverse = flag_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(ResetModulus);
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      modulus <= W'(pwdata);
    end
  end

  logic cnt_last;
  assign cnt_last = (cnt == CW'(W - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_RED_A;
      ST_RED_A:    if (modulus == '0) state_next = ST_DONE;
                   else if (cnt_last) state_next = ST_RED_B;
      ST_RED_B:    if (cnt_last) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (op)
          OP_MUL: state_next = ST_MUL;
          OP_DIV: state_next = (b == '0) ? ST_EUC_DONE : ST_EUC_DIV;
          OP_INV: state_next = (a == '0) ? ST_EUC_DONE : ST_EUC_DIV;
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL:      if (cnt_last) state_next = ST_DONE;
      ST_EUC_DIV:  if (cnt_last) state_next = ST_EUC_QMUL;
      ST_EUC_QMUL: if (cnt_last) state_next = ST_EUC_UPD;
      ST_EUC_UPD:  state_next = (r0 == '0) ? ST_EUC_DONE : ST_EUC_DIV;
      ST_EUC_DONE: begin
        if (r0 != W'(1) && !(modulus == W'(1))) state_next = ST_DONE;
        else if (euc_for_div) state_next = ST_MUL;
        else state_next = ST_DONE;
      end
      ST_DONE:     if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic [W-1:0] rem_new;
  assign rem_new = ddiff[W+1] ? dshift[W-1:0] : ddiff[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      flag_q <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op  <= opcode;
            a   <= operand_a;
            b   <= operand_b;
            quo <= operand_a;
            acc <= '0;
            cnt <= '0;
            flag_q <= 1'b0;
            res_q  <= '0;
          end
        end
        ST_RED_A, ST_RED_B: begin
          if (modulus == '0) begin
            res_q  <= '0;
            flag_q <= (op == OP_DIV || op == OP_INV);
          end else begin
            cnt <= cnt_last ? '0 : cnt + CW'(1);
            if (cnt_last) begin
              acc <= '0;
              if (state == ST_RED_A) begin
                a   <= rem_new;
                quo <= b;
              end else begin
                b <= rem_new;
              end
            end else begin
              quo <= {quo[W-2:0], ~ddiff[W+1]};
              acc <= {1'b0, rem_new};
            end
          end
        end
        ST_DISPATCH: begin
          cnt <= '0;
          acc <= '0;
          euc_for_div <= (op == OP_DIV);
          case (op)
            OP_ADD: begin
              res_q <= ({1'b0, a} + {1'b0, b} >= {1'b0, modulus}) ?
                       W'({1'b0, a} + {1'b0, b} - {1'b0, modulus}) : W'(a + b);
            end
            OP_SUB: res_q <= (a >= b) ? W'(a - b) : W'(a + (modulus - b));
            OP_NEG: res_q <= (a == '0) ? '0 : W'(modulus - a);
            OP_MUL: begin
              mx <= a;
              my <= b;
            end
            OP_DIV, OP_INV: begin
              r0 <= modulus;
              r1 <= (op == OP_DIV) ? b : a;
              t0 <= '0;
              t1 <= (modulus == W'(1)) ? '0 : W'(1);
              quo <= modulus;
            end
            default: res_q <= '0;
          endcase
        end
        ST_MUL: begin
          acc <= madd_r;
          my  <= {my[W-2:0], 1'b0};
          cnt <= cnt_last ? '0 : cnt + CW'(1);
          if (cnt_last) res_q <= madd_r[W-1:0];
        end
        ST_EUC_DIV: begin
          cnt <= cnt_last ? '0 : cnt + CW'(1);
          if (cnt_last) begin
            // quotient reduced mod m: q <= m since r1 >= 1 and r0 <= m, so q == m maps to 0
            mx  <= t1;
            my  <= ({quo[W-2:0], ~ddiff[W+1]} == modulus) ? '0 : {quo[W-2:0], ~ddiff[W+1]};
            r0  <= rem_new;
            acc <= '0;
          end else begin
            quo <= {quo[W-2:0], ~ddiff[W+1]};
            acc <= {1'b0, rem_new};
          end
        end
        ST_EUC_QMUL: begin
          acc <= madd_r;
          my  <= {my[W-2:0], 1'b0};
          cnt <= cnt_last ? '0 : cnt + CW'(1);
          if (cnt_last) quo <= madd_r[W-1:0];
        end
        ST_EUC_UPD: begin
          // r0 holds the new remainder here; swap roles
          r1  <= r0;
          r0  <= r1;
          t0  <= t1;
          t1  <= (t0 >= quo) ? W'(t0 - quo) : W'(t0 + (modulus - quo));
          quo <= r1;
          acc <= '0;
        end
        ST_EUC_DONE: begin
          cnt <= '0;
          if (r0 != W'(1) && !(modulus == W'(1))) begin
            flag_q <= 1'b1;
            res_q  <= '0;
          end else if (euc_for_div) begin
            mx  <= a;
            my  <= t0;
            acc <= '0;
          end else begin
            res_q <= t0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready and valid together");
  a_flag_zero: assert property (@(posedge clk) disable iff (rst) out_valid && no_inverse |-> result == '0)
    else $error("no_inverse with nonzero result");
  a_flag_op: assert property (@(posedge clk) disable iff (rst)
      out_valid && no_inverse |-> (op == OP_DIV || op == OP_INV))
    else $error("no_inverse on wrong op");
  a_in_range: assert property (@(posedge clk) disable iff (rst)
      out_valid && modulus != '0 |-> result < modulus)
    else $error("result out of range");
`endif

endmodule
